// ===== rtl/fmrb_pkg.sv =====
// Shared types and constants of the four-motor ramp and brake drive.
package fmrb_pkg;

	localparam int MotorCount = 4;

	localparam logic [1:0] DirBrake   = 2'd0;
	localparam logic [1:0] DirForward = 2'd1;

	localparam logic [1:0] RegRampStep  = 2'd0;
	localparam logic [1:0] RegBrakeTicks = 2'd1;
	localparam logic [1:0] RegBrakePulse = 2'd2;

	localparam logic [7:0] RampStepReset   = 8'd7;
	localparam logic [7:0] BrakeTicksReset = 8'd10;
	localparam logic [7:0] BrakePulseReset = 8'd100;

	typedef struct packed {
		logic [7:0] ramp_step;
		logic [7:0] brake_ticks;
		logic [7:0] brake_pulse;
	} cfg_t;

	typedef struct packed {
		logic [7:0] throttle;
		logic [1:0] direction;
		logic       pin_a;
		logic       pin_b;
		logic [7:0] pulse;
		logic       written;
	} lane_status_t;

	typedef struct packed {
		logic [MotorCount-1:0][7:0]   throttle;
		logic [2*MotorCount-1:0]      direction;
		logic [MotorCount-1:0]        pin_a;
		logic [MotorCount-1:0]        pin_b;
		logic [MotorCount-1:0][7:0]   pulse;
		logic [MotorCount-1:0]        written;
	} report_t;

endpackage

// ===== rtl/four_motor_ramp_brake_drive.sv =====
// Top level of the four-motor ramp and brake drive.
// Four motor lanes update in parallel on a tick and a merge
// stage registers the report; a command (mode 0) latches targets and gives no report.
// One item is accepted per cycle; in_stall rises only when both the output register
// and the skid register hold reports not yet taken. Configuration writes are always accepted
// (cfg_ready is always high) and must only be made while the block is idle.
module four_motor_ramp_brake_drive (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] throttle_0,
	input  logic [7:0] throttle_1,
	input  logic [7:0] throttle_2,
	input  logic [7:0] throttle_3,
	input  logic [7:0] direction_bits,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] current_throttle_0,
	output logic [7:0] current_throttle_1,
	output logic [7:0] current_throttle_2,
	output logic [7:0] current_throttle_3,
	output logic [7:0] direction_report,
	output logic [3:0] drive_a_pins,
	output logic [3:0] drive_b_pins,
	output logic [7:0] pulse_0,
	output logic [7:0] pulse_1,
	output logic [7:0] pulse_2,
	output logic [7:0] pulse_3,
	output logic [3:0] pulse_written,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	fmrb_pkg::cfg_t                                  cfg_q;
	fmrb_pkg::lane_status_t [fmrb_pkg::MotorCount-1:0] lanes;
	fmrb_pkg::report_t                               report;
	logic [fmrb_pkg::MotorCount-1:0][7:0]            cmd_thr;
	logic                                            accept, cmd_load, tick, busy;

	assign cfg_ready = 1'b1;
	assign accept = in_valid && !in_stall;
	assign cmd_load = accept && !mode;
	assign tick = accept && mode;
	assign in_stall = busy;

	assign cmd_thr[0] = throttle_0;
	assign cmd_thr[1] = throttle_1;
	assign cmd_thr[2] = throttle_2;
	assign cmd_thr[3] = throttle_3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_step <= fmrb_pkg::RampStepReset;
			cfg_q.brake_ticks <= fmrb_pkg::BrakeTicksReset;
			cfg_q.brake_pulse <= fmrb_pkg::BrakePulseReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fmrb_pkg::RegRampStep: cfg_q.ramp_step <= cfg_data;
				fmrb_pkg::RegBrakeTicks: cfg_q.brake_ticks <= cfg_data;
				fmrb_pkg::RegBrakePulse: cfg_q.brake_pulse <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar m = 0; m < fmrb_pkg::MotorCount; m++) begin : g_lane
		fmrb_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd_load      (cmd_load),
			.tick          (tick),
			.cmd_throttle  (cmd_thr[m]),
			.cmd_direction (direction_bits[2*m +: 2]),
			.cfg           (cfg_q),
			.status        (lanes[m])
		);
	end

	fmrb_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.lanes  (lanes),
		.busy   (busy),
		.valid  (out_valid),
		.stall  (out_stall),
		.report (report)
	);

	assign current_throttle_0 = report.throttle[0];
	assign current_throttle_1 = report.throttle[1];
	assign current_throttle_2 = report.throttle[2];
	assign current_throttle_3 = report.throttle[3];
	assign direction_report = report.direction;
	assign drive_a_pins = report.pin_a;
	assign drive_b_pins = report.pin_b;
	assign pulse_0 = report.pulse[0];
	assign pulse_1 = report.pulse[1];
	assign pulse_2 = report.pulse[2];
	assign pulse_3 = report.pulse[3];
	assign pulse_written = report.written;

`ifndef NO_ASSERTIONS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("skid full while output register empty");
	a_tick_gives_report: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && !out_valid) |=> out_valid)
		else $error("tick accepted into empty output but no report");
	a_cmd_no_report: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_load && !out_valid && !in_stall) |=> !out_valid)
		else $error("command produced a report");
	a_pins_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((drive_a_pins & drive_b_pins) == 4'd0))
		else $error("bridge pins A and B both high");
`endif

endmodule

// ===== rtl/fmrb_lane.sv =====
// One motor lane: target latch, brake dwell timer, throttle ramp and bridge pins.
module fmrb_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_load,
	input  logic                 tick,
	input  logic [7:0]           cmd_throttle,
	input  logic [1:0]           cmd_direction,
	input  fmrb_pkg::cfg_t       cfg,
	output fmrb_pkg::lane_status_t status
);

	logic [7:0] tgt_thr_q, cur_thr_q, timer_q, pulse_q;
	logic [1:0] tgt_dir_q, cur_dir_q;
	logic       pin_a_q, pin_b_q;

	logic [7:0] timer_dec, timer_nxt, up_gap, down_gap, ramped;
	logic       skip, brake;

	always_comb begin
		timer_dec = timer_q - {7'd0, (timer_q != 8'd0)};
		skip = ((cur_thr_q == tgt_thr_q) && (cur_dir_q == tgt_dir_q)) || (timer_dec != 8'd0);
		brake = (tgt_dir_q == fmrb_pkg::DirBrake) ||
			((cur_dir_q != tgt_dir_q) && (cur_thr_q != 8'd0) && (tgt_thr_q != 8'd0));
		up_gap = tgt_thr_q - cur_thr_q;
		down_gap = cur_thr_q - tgt_thr_q;
		if (tgt_thr_q >= cur_thr_q) begin
			ramped = (up_gap > cfg.ramp_step) ? cur_thr_q + cfg.ramp_step : tgt_thr_q;
		end else begin
			ramped = (down_gap > cfg.ramp_step) ? cur_thr_q - cfg.ramp_step : tgt_thr_q;
		end

		timer_nxt = timer_dec;
		status.throttle = cur_thr_q;
		status.direction = cur_dir_q;
		status.pin_a = pin_a_q;
		status.pin_b = pin_b_q;
		status.pulse = pulse_q;
		status.written = 1'b0;
		if (!skip) begin
			status.written = 1'b1;
			if (brake) begin
				status.pin_a = 1'b0;
				status.pin_b = 1'b0;
				status.pulse = cfg.brake_pulse;
				status.throttle = 8'd0;
				status.direction = fmrb_pkg::DirBrake;
				timer_nxt = cfg.brake_ticks;
			end else begin
				if (cur_thr_q == 8'd0) begin
					status.pin_a = (tgt_dir_q != fmrb_pkg::DirForward);
					status.pin_b = (tgt_dir_q == fmrb_pkg::DirForward);
					status.direction = tgt_dir_q;
				end
				status.throttle = ramped;
				status.pulse = ramped;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_thr_q <= 8'd0;
			tgt_dir_q <= fmrb_pkg::DirBrake;
			cur_thr_q <= 8'd0;
			cur_dir_q <= fmrb_pkg::DirBrake;
			timer_q <= 8'd0;
			pulse_q <= 8'd0;
			pin_a_q <= 1'b0;
			pin_b_q <= 1'b0;
		end else begin
			if (cmd_load) begin
				tgt_dir_q <= cmd_direction;
				tgt_thr_q <= (cmd_direction == fmrb_pkg::DirBrake) ? 8'd0 : cmd_throttle;
			end
			if (tick) begin
				cur_thr_q <= status.throttle;
				cur_dir_q <= status.direction;
				timer_q <= timer_nxt;
				pulse_q <= status.pulse;
				pin_a_q <= status.pin_a;
				pin_b_q <= status.pin_b;
			end
		end
	end

endmodule

// ===== rtl/fmrb_merge.sv =====
// Merge stage: gathers lane results into a report, with output register and skid stage.
module fmrb_merge (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          tick,
	input  fmrb_pkg::lane_status_t [fmrb_pkg::MotorCount-1:0] lanes,
	output logic                                          busy,
	output logic                                          valid,
	input  logic                                          stall,
	output fmrb_pkg::report_t                             report
);

	fmrb_pkg::report_t merged, out_q, skid_q;
	logic              out_valid_q, skid_valid_q;

	always_comb begin
		for (int m = 0; m < fmrb_pkg::MotorCount; m++) begin
			merged.throttle[m] = lanes[m].throttle;
			merged.direction[2*m +: 2] = lanes[m].direction;
			merged.pin_a[m] = lanes[m].pin_a;
			merged.pin_b[m] = lanes[m].pin_b;
			merged.pulse[m] = lanes[m].pulse;
			merged.written[m] = lanes[m].written;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !stall) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= tick;
			end else begin
				out_valid_q <= tick;
			end
		end else if (tick) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !stall) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				skid_q <= merged;
			end else begin
				out_q <= merged;
			end
		end else if (tick) begin
			skid_q <= merged;
		end
	end

	assign busy = skid_valid_q;
	assign valid = out_valid_q;
	assign report = out_q;

endmodule
